// ----- hdl/mds_pkg.sv -----
// Shared types, sizes, datapath commands and helper functions of the dominating set search.
package mds_pkg;

	localparam int MAX_NODES = 32;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int CMP_W     = (CNT_W > 6) ? CNT_W : 6;
	localparam int FRAME_W   = 3 * MAX_NODES;

	typedef logic [MAX_NODES-1:0] mask_t;
	typedef logic [NODE_W-1:0]    node_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	localparam int OP_W = 4;
	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_NONE      = 4'd0;
	localparam op_t OP_LOAD      = 4'd1;
	localparam op_t OP_FIX       = 4'd2;
	localparam op_t OP_ACC_INIT  = 4'd3;
	localparam op_t OP_ACC       = 4'd4;
	localparam op_t OP_SRCH_INIT = 4'd5;
	localparam op_t OP_ENTER     = 4'd6;
	localparam op_t OP_EXPAND    = 4'd7;
	localparam op_t OP_PUSH      = 4'd8;
	localparam op_t OP_POP       = 4'd9;
	localparam op_t OP_FINISH    = 4'd10;

	typedef struct packed {
		op_t  op;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic idx_end;
		logic prune;
		logic cand_zero;
		logic sp_zero;
		logic out_busy;
	} stat_t;

	function automatic mask_t onehot(input node_t v);
		mask_t m;
		m = '0;
		m[v] = 1'b1;
		return m;
	endfunction

	function automatic node_t lowest(input mask_t m);
		node_t r;
		r = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = NODE_W'(i);
			end
		end
		return r;
	endfunction

	function automatic cnt_t eff_count(input logic [5:0] raw);
		cnt_t r;
		if (CMP_W'(raw) > CMP_W'(MAX_NODES)) begin
			r = CNT_W'(MAX_NODES);
		end else begin
			r = CNT_W'(raw);
		end
		return r;
	endfunction

	function automatic mask_t mask_below(input cnt_t n);
		mask_t m;
		m = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			m[i] = (CNT_W'(i) < n);
		end
		return m;
	endfunction

endpackage

// ----- hdl/min_dominating_set_search.sv -----
// Top level of the minimum dominating set search block.
// Input stream: one request per edge. s_tdata carries node_count, endpoint_a and
// endpoint_b, s_tuser flags a request that carries an edge, s_tlast ends the graph.
// Edge requests are taken one per cycle while s_tready is high; endpoints at or above node_count are dropped.
// The request with s_tlast starts the search and s_tready stays low until its result
// is handed to the output register.
// After the last request: a fixing sweep, a cover sweep, then a depth-first search whose
// length depends on the graph: a bound check at the root, a push and a bound check per
// branch taken, an expand and a last candidate test per node expanded, a return and a pop
// per return to a parent and a return and the result to finish, with the frame stack held
// in one RAM with a registered read port.
// Output stream: one request per graph on m_tdata carrying min_size.
// The result waits in an output register while m_tready is low; edges of the next
// graph are still taken meanwhile, and the next search result holds until it drains.
// Emitting a result clears the adjacency and degree stores in the same cycle.
// Reset clears the adjacency and degree stores, drops m_tvalid and leaves the block ready for edges.
module min_dominating_set_search
	import mds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // node_count[5:0], endpoint_a[10:6], endpoint_b[15:11]
	input  logic [0:0]  s_tuser,  // edge_valid[0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // min_size[5:0], zero[7:6]
);

	cmd_t       cmd;
	stat_t      stat;
	logic [5:0] min_size;

	mds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mds_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.node_count (s_tdata[5:0]),
		.endpoint_a (s_tdata[10:6]),
		.endpoint_b (s_tdata[15:11]),
		.edge_valid (s_tuser[0]),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.min_size   (min_size)
	);

	assign m_tdata = {2'b00, min_size};

endmodule

// ----- hdl/mds_ram.sv -----
// Generic single write port RAM with one registered read port.
module mds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/mds_graph.sv -----
// Graph store: adjacency rows, saturating degree counts and first neighbours.
module mds_graph
	import mds_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       clr,
	input  node_t      a_idx,
	input  node_t      b_idx,
	input  node_t      rd_addr,
	output mask_t      rd_row,
	output logic [1:0] rd_deg,
	output node_t      rd_fn
);

	mask_t      adj_q [MAX_NODES];
	mask_t      adj_d [MAX_NODES];
	logic [1:0] deg_q [MAX_NODES];
	logic [1:0] deg_d [MAX_NODES];
	node_t      fn_q  [MAX_NODES];
	node_t      fn_d  [MAX_NODES];

	always_comb begin
		logic       hit_a;
		logic       hit_b;
		logic [1:0] inc;
		logic [2:0] sum;
		hit_a = 1'b0;
		hit_b = 1'b0;
		inc   = '0;
		sum   = '0;
		adj_d = adj_q;
		deg_d = deg_q;
		fn_d  = fn_q;
		if (load) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				hit_a = (NODE_W'(i) == a_idx);
				hit_b = (NODE_W'(i) == b_idx);
				inc   = {1'b0, hit_a} + {1'b0, hit_b};
				sum   = {1'b0, deg_q[i]} + {1'b0, inc};
				deg_d[i] = (sum > 3'd2) ? 2'd2 : sum[1:0];
				if (hit_a) begin
					adj_d[i][b_idx] = 1'b1;
				end
				if (hit_b) begin
					adj_d[i][a_idx] = 1'b1;
				end
				if (deg_q[i] == 2'd0 && (hit_a || hit_b)) begin
					fn_d[i] = hit_a ? b_idx : a_idx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				adj_q[i] <= '0;
				deg_q[i] <= '0;
			end
		end else if (clr) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				adj_q[i] <= '0;
				deg_q[i] <= '0;
			end
		end else if (load) begin
			adj_q <= adj_d;
			deg_q <= deg_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fn_q <= fn_d;
		end
	end

	assign rd_row = adj_q[rd_addr];
	assign rd_deg = deg_q[rd_addr];
	assign rd_fn  = fn_q[rd_addr];

endmodule

// ----- hdl/mds_dp.sv -----
// Datapath: graph store, fixing and cover sweeps, search frame registers and frame stack.
module mds_dp
	import mds_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output stat_t      stat,
	input  logic [5:0] node_count,
	input  logic [4:0] endpoint_a,
	input  logic [4:0] endpoint_b,
	input  logic       edge_valid,
	input  logic       m_tready,
	output logic       m_tvalid,
	output logic [5:0] min_size
);

	cnt_t  n_q;
	mask_t full_q;
	cnt_t  idx_q;
	mask_t chosen_q;
	mask_t fixed_q;
	mask_t dom_q;
	mask_t excl_q;
	mask_t cand_q;
	cnt_t  cost_q;
	cnt_t  best_q;
	node_t u_q;
	cnt_t  sp_q;
	logic  out_valid_q;
	cnt_t  out_size_q;

	cnt_t               n_in;
	logic               load_edge;
	node_t              a_idx;
	node_t              b_idx;
	node_t              rd_addr;
	node_t              v_sel;
	mask_t              v_bit;
	mask_t              rd_row;
	mask_t              nbhd;
	logic [1:0]         rd_deg;
	node_t              rd_fn;
	mask_t              open_set;
	cnt_t               sp_m1;
	logic [FRAME_W-1:0] push_frame;
	logic [FRAME_W-1:0] pop_frame;
	node_t              idx_node;

	assign n_in      = eff_count(node_count);
	assign a_idx     = NODE_W'(endpoint_a);
	assign b_idx     = NODE_W'(endpoint_b);
	assign load_edge = (cmd.op == OP_LOAD) && edge_valid
		&& (CMP_W'(endpoint_a) < CMP_W'(n_in))
		&& (CMP_W'(endpoint_b) < CMP_W'(n_in));

	assign idx_node = idx_q[NODE_W-1:0];
	assign v_sel    = lowest(cand_q);
	assign v_bit    = onehot(v_sel);

	always_comb begin
		case (cmd.op)
			OP_FIX, OP_ACC: rd_addr = idx_node;
			OP_EXPAND:      rd_addr = u_q;
			default:        rd_addr = v_sel;
		endcase
	end

	mds_graph u_graph (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load_edge),
		.clr     (cmd.op == OP_FINISH),
		.a_idx   (a_idx),
		.b_idx   (b_idx),
		.rd_addr (rd_addr),
		.rd_row  (rd_row),
		.rd_deg  (rd_deg),
		.rd_fn   (rd_fn)
	);

	assign nbhd       = rd_row | onehot(rd_addr);
	assign open_set   = full_q & ~dom_q;
	assign sp_m1      = sp_q - CNT_W'(1);
	assign push_frame = {cand_q & ~v_bit, excl_q | v_bit, dom_q};

	mds_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (MAX_NODES)
	) u_stack (
		.clk   (clk),
		.we    (cmd.op == OP_PUSH),
		.waddr (sp_q[NODE_W-1:0]),
		.wdata (push_frame),
		.raddr (sp_m1[NODE_W-1:0]),
		.rdata (pop_frame)
	);

	assign stat.idx_end   = (idx_q >= n_q);
	assign stat.prune     = (cost_q >= best_q) || (open_set == '0)
		|| (({1'b0, cost_q} + {{CNT_W{1'b0}}, 1'b1}) >= {1'b0, best_q});
	assign stat.cand_zero = (cand_q == '0);
	assign stat.sp_zero   = (sp_q == '0);
	assign stat.out_busy  = out_valid_q && !m_tready;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				if (cmd.last) begin
					n_q      <= n_in;
					full_q   <= mask_below(n_in);
					chosen_q <= '0;
					fixed_q  <= '0;
				end
			end
			OP_FIX: begin
				if (!fixed_q[idx_node]) begin
					if (rd_deg == 2'd0) begin
						chosen_q <= chosen_q | onehot(idx_node);
						fixed_q  <= fixed_q | onehot(idx_node);
					end else if (rd_deg == 2'd1 && CNT_W'(rd_fn) < n_q) begin
						chosen_q <= chosen_q | onehot(rd_fn);
						fixed_q  <= fixed_q | onehot(idx_node) | onehot(rd_fn);
					end
				end
			end
			OP_ACC_INIT: begin
				dom_q  <= '0;
				cost_q <= '0;
			end
			OP_ACC: begin
				if (chosen_q[idx_node]) begin
					dom_q  <= dom_q | nbhd;
					cost_q <= cost_q + CNT_W'(1);
				end
			end
			OP_SRCH_INIT: begin
				best_q <= n_q;
				excl_q <= fixed_q;
			end
			OP_ENTER: begin
				if (open_set == '0 && cost_q < best_q) begin
					best_q <= cost_q;
				end
				u_q <= lowest(open_set);
			end
			OP_EXPAND: begin
				cand_q <= nbhd & full_q & ~excl_q;
			end
			OP_PUSH: begin
				dom_q  <= dom_q | nbhd;
				cost_q <= cost_q + CNT_W'(1);
			end
			OP_POP: begin
				{cand_q, excl_q, dom_q} <= pop_frame;
				cost_q <= cost_q - CNT_W'(1);
			end
			OP_FINISH: begin
				out_size_q <= best_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD:      if (cmd.last) idx_q <= '0;
				OP_FIX:       idx_q <= idx_q + CNT_W'(1);
				OP_ACC_INIT:  idx_q <= '0;
				OP_ACC:       idx_q <= idx_q + CNT_W'(1);
				OP_SRCH_INIT: sp_q <= '0;
				OP_PUSH:      sp_q <= sp_q + CNT_W'(1);
				OP_POP:       sp_q <= sp_m1;
				default: begin
				end
			endcase
			if (cmd.op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign min_size = 6'(out_size_q);

endmodule

// ----- hdl/mds_ctrl.sv -----
// Controller state machine: load, fixing sweep, cover sweep, depth-first search, result.
module mds_ctrl
	import mds_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	input  logic  s_tlast,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [3:0] ST_LOAD   = 4'd0;
	localparam logic [3:0] ST_FIX    = 4'd1;
	localparam logic [3:0] ST_ACC    = 4'd2;
	localparam logic [3:0] ST_ENTER  = 4'd3;
	localparam logic [3:0] ST_EXPAND = 4'd4;
	localparam logic [3:0] ST_ITER   = 4'd5;
	localparam logic [3:0] ST_RET    = 4'd6;
	localparam logic [3:0] ST_POP    = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.last = s_tlast;
		s_tready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = OP_LOAD;
					if (s_tlast) begin
						state_d = ST_FIX;
					end
				end
			end
			ST_FIX: begin
				if (stat.idx_end) begin
					cmd.op  = OP_ACC_INIT;
					state_d = ST_ACC;
				end else begin
					cmd.op = OP_FIX;
				end
			end
			ST_ACC: begin
				if (stat.idx_end) begin
					cmd.op  = OP_SRCH_INIT;
					state_d = ST_ENTER;
				end else begin
					cmd.op = OP_ACC;
				end
			end
			ST_ENTER: begin
				cmd.op  = OP_ENTER;
				state_d = stat.prune ? ST_RET : ST_EXPAND;
			end
			ST_EXPAND: begin
				cmd.op  = OP_EXPAND;
				state_d = ST_ITER;
			end
			ST_ITER: begin
				if (stat.cand_zero) begin
					state_d = ST_RET;
				end else begin
					cmd.op  = OP_PUSH;
					state_d = ST_ENTER;
				end
			end
			ST_RET: begin
				state_d = stat.sp_zero ? ST_DONE : ST_POP;
			end
			ST_POP: begin
				cmd.op  = OP_POP;
				state_d = ST_ITER;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_FINISH;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
